[design/lgge_pkg.sv]
`default_nettype none

package lgge_pkg;

	// Request operation codes
	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [1:0] FUNC_READ    = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 2'd1;
	localparam logic [CFG_DATA_W-1:0] ACTIVE_ROWS_RESET = 7'd64;
	localparam logic [CFG_DATA_W-1:0] ACTIVE_COLS_RESET = 7'd64;

	// B3/S23 neighbor counts
	localparam logic [3:0] STAY_COUNT  = 4'd2;
	localparam logic [3:0] BIRTH_COUNT = 4'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] row_index;
		logic [5:0] col_index;
		logic       cell_value;
	} req_t;

	typedef struct packed {
		logic cell_alive;
		logic coord_error;
	} rsp_t;

endpackage

`default_nettype wire

[design/life_grid_generation_engine_core.sv]
// Conway life grid engine, B3/S23 with eight neighbors and no wrap-around. The grid of
// MAX_ROWS x MAX_COLS cells sits in a row-wide RAM (one row per word). Registers 0 and 1
// set the active rows and columns; cells outside that area count as dead and are never
// changed by a generation. Each request on req (write cell, read cell, advance one
// generation) yields exactly one response on rsp. After reset the block sweeps the RAM
// to all dead, one row per cycle, and holds req_ready low meanwhile. One request is in
// flight at a time. An in-area write or read has the RAM read at the accept edge, then
// merge or bit pick, then response staging, and the block takes the next request once
// staging is done. A request with a coordinate outside the active area, the unused
// code, or a generation over zero active rows goes straight to response staging. A
// generation covers eff_rows, which is active_rows clamped to MAX_ROWS: the sequencer
// streams rows out of the RAM's single read port one per cycle, a shared row evaluator
// computes the next state of one full row per cycle from a three-row window, and the
// result goes back through the write port. A response held by rsp_ready low stalls the
// block in its staging step until the previous response is taken.
// Configuration writes are always taken (cfg_ready is tied high) and apply at once.
`default_nettype none

module life_grid_generation_engine_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_ready,
	input  wire lgge_pkg::req_t                      req,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_ready,
	output lgge_pkg::rsp_t                           rsp,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lgge_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lgge_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lgge_pkg::*;

	localparam int AW  = $clog2(MAX_ROWS);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int CIW = $clog2(MAX_COLS);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_GEN    = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CFG_DATA_W-1:0] active_rows_q;
	logic [CFG_DATA_W-1:0] active_cols_q;
	logic [AW-1:0]         clr_q;
	logic [RCW-1:0]        rd_row_q;
	logic [RCW-1:0]        wr_row_q;
	logic                  pend_s1;
	logic                  cur_vld_q;
	logic                  out_valid_q;
	req_t                  req_q;
	rsp_t                  res_q;
	rsp_t                  rsp_q;
	logic [MAX_COLS-1:0]   prev_q;
	logic [MAX_COLS-1:0]   cur_q;

	logic [RCW-1:0]        eff_rows;
	logic [CCW-1:0]        eff_cols;
	logic [MAX_COLS-1:0]   col_mask;
	logic                  req_fire;
	logic                  req_inside;
	logic                  out_free;
	logic                  rd_issue;

	logic                  ram_wr_en;
	logic [AW-1:0]         ram_wr_addr;
	logic [MAX_COLS-1:0]   ram_wr_data;
	logic                  ram_rd_en;
	logic [AW-1:0]         ram_rd_addr;
	logic [MAX_COLS-1:0]   ram_rd_data;
	logic [MAX_COLS-1:0]   merged_row;
	logic [MAX_COLS-1:0]   below_row;
	logic [MAX_COLS-1:0]   new_row;

	// Clamp the registers to the physical grid
	assign eff_rows = (32'(active_rows_q) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS)
		: RCW'(active_rows_q);
	assign eff_cols = (32'(active_cols_q) > 32'(MAX_COLS)) ? CCW'(MAX_COLS)
		: CCW'(active_cols_q);

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
		assign col_mask[c] = (32'(c) < 32'(eff_cols));
	end

	assign req_ready  = (state_q == ST_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign req_inside = (32'(req.row_index) < 32'(eff_rows))
		&& (32'(req.col_index) < 32'(eff_cols));
	assign out_free   = !out_valid_q || rsp_ready;
	assign rd_issue   = (state_q == ST_GEN) && (rd_row_q < eff_rows);

	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// Merge the written bit into the fetched row
	always_comb begin
		merged_row = ram_rd_data;
		merged_row[CIW'(req_q.col_index)] = req_q.cell_value;
	end

	// Next row of the window, dead past the last active row
	assign below_row = pend_s1 ? ram_rd_data : '0;

	lgge_row_unit #(
		.COLS(MAX_COLS)
	) u_row_unit (
		.above   (prev_q & col_mask),
		.center  (cur_q & col_mask),
		.below   (below_row & col_mask),
		.keep    (cur_q),
		.mask    (col_mask),
		.next_row(new_row)
	);

	// RAM port steering
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
			end
			ST_IDLE: begin
				ram_rd_en   = req_fire && req_inside
					&& (req.func == FUNC_WRITE || req.func == FUNC_READ);
				ram_rd_addr = AW'(req.row_index);
			end
			ST_ACCESS: begin
				ram_wr_en   = (req_q.func == FUNC_WRITE);
				ram_wr_addr = AW'(req_q.row_index);
				ram_wr_data = merged_row;
			end
			ST_GEN: begin
				ram_rd_en   = rd_issue;
				ram_rd_addr = rd_row_q[AW-1:0];
				ram_wr_en   = cur_vld_q;
				ram_wr_addr = wr_row_q[AW-1:0];
				ram_wr_data = new_row;
			end
			default: begin
			end
		endcase
	end

	lgge_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_grid_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Configuration registers: take effect at once, unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q <= ACTIVE_ROWS_RESET;
			active_cols_q <= ACTIVE_COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ACTIVE_ROWS) begin
				active_rows_q <= cfg_data;
			end else if (cfg_index == CFG_ACTIVE_COLS) begin
				active_cols_q <= cfg_data;
			end
		end
	end

	// Response valid: raise when a staged response moves out, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp_valid && rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_row_q    <= '0;
			wr_row_q    <= '0;
			pend_s1     <= 1'b0;
			cur_vld_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					// Sweep all rows to dead
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						if (req.func == FUNC_ADVANCE) begin
							rd_row_q  <= '0;
							wr_row_q  <= '0;
							pend_s1   <= 1'b0;
							cur_vld_q <= 1'b0;
							state_q   <= (eff_rows == '0) ? ST_RESP : ST_GEN;
						end else if ((req.func == FUNC_WRITE || req.func == FUNC_READ)
								&& req_inside) begin
							state_q <= ST_ACCESS;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_ACCESS: begin
					state_q <= ST_RESP;
				end
				ST_GEN: begin
					// Stream rows in, retire one computed row per cycle
					if (rd_issue) begin
						rd_row_q <= rd_row_q + 1'b1;
					end
					pend_s1 <= rd_issue;
					if (pend_s1) begin
						cur_vld_q <= 1'b1;
					end
					if (cur_vld_q) begin
						wr_row_q <= wr_row_q + 1'b1;
						if (!pend_s1) begin
							cur_vld_q <= 1'b0;
							state_q   <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					// Hold until the output register frees
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
			res_q.cell_alive  <= 1'b0;
			res_q.coord_error <= (req.func == FUNC_WRITE || req.func == FUNC_READ)
				&& !req_inside;
			if (req.func == FUNC_ADVANCE) begin
				prev_q <= '0;
			end
		end
		if (state_q == ST_ACCESS) begin
			res_q.cell_alive <= (req_q.func == FUNC_READ)
				&& ram_rd_data[CIW'(req_q.col_index)];
		end
		if (state_q == ST_GEN) begin
			if (cur_vld_q) begin
				prev_q <= cur_q;
			end
			if (pend_s1) begin
				cur_q <= ram_rd_data;
			end
		end
		if (state_q == ST_RESP && out_free) begin
			rsp_q <= res_q;
		end
	end

endmodule

`default_nettype wire

[design/lgge_ram.sv]
`default_nettype none

module lgge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[design/lgge_row_unit.sv]
`default_nettype none

module lgge_row_unit #(
	parameter int COLS = 64
) (
	input  wire logic [COLS-1:0] above,
	input  wire logic [COLS-1:0] center,
	input  wire logic [COLS-1:0] below,
	input  wire logic [COLS-1:0] keep,
	input  wire logic [COLS-1:0] mask,
	output logic      [COLS-1:0] next_row
);
	import lgge_pkg::*;

	logic [COLS+1:0] above_p;
	logic [COLS+1:0] center_p;
	logic [COLS+1:0] below_p;

	// Pad one dead cell on each side: no wrap-around
	assign above_p  = {1'b0, above, 1'b0};
	assign center_p = {1'b0, center, 1'b0};
	assign below_p  = {1'b0, below, 1'b0};

	for (genvar c = 0; c < COLS; c++) begin : g_lane
		logic [3:0] count;
		logic       live;

		assign count = 4'(above_p[c]) + 4'(above_p[c+1]) + 4'(above_p[c+2])
			+ 4'(center_p[c]) + 4'(center_p[c+2])
			+ 4'(below_p[c]) + 4'(below_p[c+1]) + 4'(below_p[c+2]);
		assign live = (count == BIRTH_COUNT) || (center[c] && (count == STAY_COUNT));
		// Columns outside the active area hold their stored value
		assign next_row[c] = mask[c] ? live : keep[c];
	end

endmodule

`default_nettype wire
